// ===== rtl/mlss_pkg.sv =====
// Shared types and constants for the multiplayer link slot synchronizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mlss_pkg;

   localparam int MAX_SLOTS   = 4;
   localparam int SLOT_COUNT  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [31:0] LINK_MAGIC   = 32'h4C4E4B31;
   localparam logic [31:0] KIND_REQUEST = 32'h0000_0000;
   localparam logic [31:0] KIND_RESPONSE = 32'h0000_0001;
   localparam logic [15:0] PACKET_BYTES = 16'd20;
   localparam logic [15:0] IDLE_WORD    = 16'hffff;

   localparam logic TX_REQUEST  = 1'b0;
   localparam logic TX_RESPONSE = 1'b1;

   localparam logic [1:0] CMD_RESET   = 2'd0;
   localparam logic [1:0] CMD_SEND    = 2'd1;
   localparam logic [1:0] CMD_RECEIVE = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam logic CSR_OWN_ID       = 1'b0;
   localparam logic CSR_PLAYER_COUNT = 1'b1;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_SEND     = 3'd1,
      OP_REQUEST  = 3'd2,
      OP_RESPONSE = 3'd3,
      OP_TICK     = 3'd4,
      OP_DROP     = 3'd5
   } op_type;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      op_type                 op;
      logic [31:0]            seq;
      logic [15:0]            data;
      logic [15:0]            reply;
      logic [MAX_SLOTS-1:0]   sender_mask;
      logic [2:0]             info;
      logic                   irq;
   } cmd_type;

endpackage

// ===== rtl/mlss_front.sv =====
// Front end: accepts request transactions, validates packets and decodes them.
// Depends on mlss_pkg for the command struct and link constants.
module mlss_front #(
   parameter int SLOT_COUNT = mlss_pkg::SLOT_COUNT
) (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic [15:0]          req_send_value,
   input  logic [15:0]          req_packet_length,
   input  logic [31:0]          req_packet_header,
   input  logic [31:0]          req_packet_kind,
   input  logic [31:0]          req_packet_sequence,
   input  logic [31:0]          req_packet_info,
   input  logic [31:0]          req_packet_payload,
   input  logic [15:0]          req_sender_id,
   input  logic [15:0]          req_local_reply_value,
   input  logic                 req_irq_enable,
   input  logic                 queue_full,
   output logic                 push,
   output mlss_pkg::cmd_type    cmd
);

   logic packet_ok;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign packet_ok = (req_packet_length == mlss_pkg::PACKET_BYTES) &&
                      (req_packet_header == mlss_pkg::LINK_MAGIC);

   always_comb begin
      cmd       = '0;
      cmd.op    = mlss_pkg::OP_DROP;
      cmd.seq   = req_packet_sequence;
      cmd.reply = req_local_reply_value;
      cmd.irq   = req_irq_enable;
      cmd.data  = req_packet_payload[15:0];
      cmd.info  = (req_packet_info > 32'(SLOT_COUNT)) ? 3'(SLOT_COUNT)
                                                      : req_packet_info[2:0];
      for (int s = 0; s < mlss_pkg::MAX_SLOTS; s++) begin
         cmd.sender_mask[s] = (s < SLOT_COUNT) && (req_sender_id == 16'(s));
      end
      unique case (req_command)
         mlss_pkg::CMD_RESET: cmd.op = mlss_pkg::OP_CLEAR;
         mlss_pkg::CMD_SEND: begin
            cmd.op   = mlss_pkg::OP_SEND;
            cmd.data = req_send_value;
         end
         mlss_pkg::CMD_RECEIVE: begin
            if (packet_ok && req_packet_kind == mlss_pkg::KIND_REQUEST) begin
               cmd.op = mlss_pkg::OP_REQUEST;
            end else if (packet_ok && req_packet_kind == mlss_pkg::KIND_RESPONSE) begin
               cmd.op = mlss_pkg::OP_RESPONSE;
            end
         end
         mlss_pkg::CMD_TICK: cmd.op = mlss_pkg::OP_TICK;
         default: cmd.op = mlss_pkg::OP_DROP;
      endcase
   end

endmodule

// ===== rtl/mlss_queue.sv =====
// Two-entry queue of decoded commands between the front and back ends.
// Depends on mlss_pkg for the command struct and queue depth.
module mlss_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mlss_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output logic                 head_valid,
   output mlss_pkg::cmd_type    head_cmd,
   output logic                 full
);

   localparam logic [mlss_pkg::QPTR_W:0] COUNT_ONE = (mlss_pkg::QPTR_W + 1)'(1);

   mlss_pkg::cmd_type                   entry_ff [mlss_pkg::QUEUE_DEPTH];
   logic [mlss_pkg::QPTR_W-1:0]         wptr_ff, wptr_in;
   logic [mlss_pkg::QPTR_W-1:0]         rptr_ff, rptr_in;
   logic [mlss_pkg::QPTR_W:0]           count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (mlss_pkg::QPTR_W + 1)'(mlss_pkg::QUEUE_DEPTH));
   assign head_cmd   = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/mlss_back.sv =====
// Back end: holds the player slots and settings, executes commands and
// registers one response transaction each. Depends on mlss_pkg.
module mlss_back #(
   parameter int SLOT_COUNT = mlss_pkg::SLOT_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 head_valid,
   input  mlss_pkg::cmd_type    head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_tx_valid,
   output logic                 rsp_tx_kind,
   output logic [31:0]          rsp_tx_sequence,
   output logic [2:0]           rsp_tx_info,
   output logic [15:0]          rsp_tx_data,
   output logic                 rsp_regs_valid,
   output logic [15:0]          rsp_multi_word0,
   output logic [15:0]          rsp_multi_word1,
   output logic [15:0]          rsp_multi_word2,
   output logic [15:0]          rsp_multi_word3,
   output logic                 rsp_raise_irq
);

   logic [31:0] seq_ff   [SLOT_COUNT];
   logic [31:0] seq_in   [SLOT_COUNT];
   logic [15:0] value_ff [SLOT_COUNT];
   logic [15:0] value_in [SLOT_COUNT];
   logic [2:0]  pending_ff, pending_in;
   logic [15:0] own_id_ff;
   logic [2:0]  player_count_ff;

   logic        rsp_valid_ff;
   logic        tx_valid_ff, tx_valid_in;
   logic        tx_kind_ff, tx_kind_in;
   logic [31:0] tx_seq_ff, tx_seq_in;
   logic [2:0]  tx_info_ff, tx_info_in;
   logic [15:0] tx_data_ff, tx_data_in;
   logic        regs_valid_ff, regs_valid_in;
   logic [15:0] word_ff [mlss_pkg::MAX_SLOTS];
   logic [15:0] word_in [mlss_pkg::MAX_SLOTS];
   logic        irq_ff, irq_in;

   logic [15:0] value_pad [mlss_pkg::MAX_SLOTS];
   logic [31:0] seq0_next;
   logic [2:0]  count_clamped;
   logic        own_in_range;
   logic        in_sync;

   // Slots past the configured count read as idle words on delivery.
   for (genvar g = 0; g < mlss_pkg::MAX_SLOTS; g++) begin : g_pad
      if (g < SLOT_COUNT) begin : g_live
         assign value_pad[g] = value_ff[g];
      end else begin : g_idle
         assign value_pad[g] = mlss_pkg::IDLE_WORD;
      end
   end

   assign pop           = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign seq0_next     = seq_ff[0] + 32'd1;
   assign own_in_range  = (own_id_ff < 16'(SLOT_COUNT));
   assign count_clamped = (player_count_ff > 3'(SLOT_COUNT)) ? 3'(SLOT_COUNT)
                                                             : player_count_ff;

   always_comb begin
      in_sync = (pending_ff != 3'd0);
      for (int i = 1; i < SLOT_COUNT; i++) begin
         if ((3'(i) < pending_ff) && (seq_ff[i] != seq_ff[0])) begin
            in_sync = 1'b0;
         end
      end
   end

   always_comb begin
      seq_in        = seq_ff;
      value_in      = value_ff;
      pending_in    = pending_ff;
      tx_valid_in   = 1'b0;
      tx_kind_in    = mlss_pkg::TX_REQUEST;
      tx_seq_in     = '0;
      tx_info_in    = '0;
      tx_data_in    = '0;
      regs_valid_in = 1'b0;
      irq_in        = 1'b0;
      for (int i = 0; i < mlss_pkg::MAX_SLOTS; i++) begin
         word_in[i] = '0;
      end
      unique case (head_cmd.op)
         mlss_pkg::OP_CLEAR: begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
               seq_in[s]   = '0;
               value_in[s] = '0;
            end
            pending_in    = '0;
            regs_valid_in = 1'b1;
            for (int i = 0; i < mlss_pkg::MAX_SLOTS; i++) begin
               word_in[i] = mlss_pkg::IDLE_WORD;
            end
         end
         mlss_pkg::OP_SEND: begin
            seq_in[0]   = seq0_next;
            value_in[0] = head_cmd.data;
            pending_in  = count_clamped;
            tx_valid_in = 1'b1;
            tx_kind_in  = mlss_pkg::TX_REQUEST;
            tx_seq_in   = seq0_next;
            tx_info_in  = count_clamped;
            tx_data_in  = head_cmd.data;
         end
         mlss_pkg::OP_REQUEST, mlss_pkg::OP_RESPONSE: begin
            // For a request the own slot takes priority over the sender's, so it wins a tie.
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (head_cmd.op == mlss_pkg::OP_REQUEST && own_id_ff == 16'(s)) begin
                  seq_in[s]   = head_cmd.seq;
                  value_in[s] = head_cmd.reply;
               end else if (head_cmd.sender_mask[s]) begin
                  seq_in[s]   = head_cmd.seq;
                  value_in[s] = head_cmd.data;
               end
            end
            if (head_cmd.op == mlss_pkg::OP_REQUEST && own_in_range) begin
               pending_in  = head_cmd.info;
               tx_valid_in = 1'b1;
               tx_kind_in  = mlss_pkg::TX_RESPONSE;
               tx_seq_in   = head_cmd.seq;
               tx_data_in  = head_cmd.reply;
            end
         end
         mlss_pkg::OP_TICK: begin
            if (in_sync) begin
               for (int i = 0; i < mlss_pkg::MAX_SLOTS; i++) begin
                  word_in[i] = (3'(i) < pending_ff) ? value_pad[i] : mlss_pkg::IDLE_WORD;
               end
               pending_in    = '0;
               regs_valid_in = 1'b1;
               irq_in        = head_cmd.irq;
            end
         end
         mlss_pkg::OP_DROP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            seq_ff[s]   <= '0;
            value_ff[s] <= '0;
         end
         pending_ff      <= '0;
         own_id_ff       <= '0;
         player_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               mlss_pkg::CSR_OWN_ID:       own_id_ff       <= csr_wdata;
               mlss_pkg::CSR_PLAYER_COUNT: player_count_ff <= csr_wdata[2:0];
               default: ;
            endcase
         end
         if (pop) begin
            seq_ff     <= seq_in;
            value_ff   <= value_in;
            pending_ff <= pending_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tx_valid_ff   <= tx_valid_in;
         tx_kind_ff    <= tx_kind_in;
         tx_seq_ff     <= tx_seq_in;
         tx_info_ff    <= tx_info_in;
         tx_data_ff    <= tx_data_in;
         regs_valid_ff <= regs_valid_in;
         word_ff       <= word_in;
         irq_ff        <= irq_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_valid    = tx_valid_ff;
   assign rsp_tx_kind     = tx_kind_ff;
   assign rsp_tx_sequence = tx_seq_ff;
   assign rsp_tx_info     = tx_info_ff;
   assign rsp_tx_data     = tx_data_ff;
   assign rsp_regs_valid  = regs_valid_ff;
   assign rsp_multi_word0 = word_ff[0];
   assign rsp_multi_word1 = word_ff[1];
   assign rsp_multi_word2 = word_ff[2];
   assign rsp_multi_word3 = word_ff[3];
   assign rsp_raise_irq   = irq_ff;

endmodule

// ===== rtl/multiplayer_link_slot_sync_top.sv =====
// Top level of the multiplayer link slot synchronizer.
// Instantiates mlss_front, mlss_queue and mlss_back; depends on mlss_pkg.
//
//   Port group | Direction | Handshake              | Carries
//   req_*      | in        | req_valid / req_stall  | one command transaction
//   rsp_*      | out       | rsp_valid / rsp_stall  | one result transaction
//   csr_*      | in        | csr_write              | own id and player count
//
// One transaction per cycle is sustained while rsp_stall stays low; each result
// passes through the command queue and then the result register before it is
// presented on the rsp_* ports.
// The two-entry command queue sets how far requests run ahead of a stalled
// result channel; req_stall rises only when that queue is full.
// Reset is synchronous and clears the slots, settings and both handshakes.
module multiplayer_link_slot_sync_top #(
   parameter int SLOT_COUNT = mlss_pkg::SLOT_COUNT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  logic [15:0]   req_send_value,
   input  logic [15:0]   req_packet_length,
   input  logic [31:0]   req_packet_header,
   input  logic [31:0]   req_packet_kind,
   input  logic [31:0]   req_packet_sequence,
   input  logic [31:0]   req_packet_info,
   input  logic [31:0]   req_packet_payload,
   input  logic [15:0]   req_sender_id,
   input  logic [15:0]   req_local_reply_value,
   input  logic          req_irq_enable,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_tx_valid,
   output logic          rsp_tx_kind,
   output logic [31:0]   rsp_tx_sequence,
   output logic [2:0]    rsp_tx_info,
   output logic [15:0]   rsp_tx_data,
   output logic          rsp_regs_valid,
   output logic [15:0]   rsp_multi_word0,
   output logic [15:0]   rsp_multi_word1,
   output logic [15:0]   rsp_multi_word2,
   output logic [15:0]   rsp_multi_word3,
   output logic          rsp_raise_irq
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              head_valid;
   mlss_pkg::cmd_type push_cmd;
   mlss_pkg::cmd_type head_cmd;

   mlss_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_send_value        (req_send_value),
      .req_packet_length     (req_packet_length),
      .req_packet_header     (req_packet_header),
      .req_packet_kind       (req_packet_kind),
      .req_packet_sequence   (req_packet_sequence),
      .req_packet_info       (req_packet_info),
      .req_packet_payload    (req_packet_payload),
      .req_sender_id         (req_sender_id),
      .req_local_reply_value (req_local_reply_value),
      .req_irq_enable        (req_irq_enable),
      .queue_full            (queue_full),
      .push                  (push),
      .cmd                   (push_cmd)
   );

   mlss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (queue_full)
   );

   mlss_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_kind     (rsp_tx_kind),
      .rsp_tx_sequence (rsp_tx_sequence),
      .rsp_tx_info     (rsp_tx_info),
      .rsp_tx_data     (rsp_tx_data),
      .rsp_regs_valid  (rsp_regs_valid),
      .rsp_multi_word0 (rsp_multi_word0),
      .rsp_multi_word1 (rsp_multi_word1),
      .rsp_multi_word2 (rsp_multi_word2),
      .rsp_multi_word3 (rsp_multi_word3),
      .rsp_raise_irq   (rsp_raise_irq)
   );

   // A result never both broadcasts a packet and writes the multi registers.
   a_tx_regs_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_regs_valid))
      else $error("result carries both a packet and a register delivery");

   // The interrupt is only requested together with a register delivery.
   a_irq_needs_regs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_raise_irq) |-> rsp_regs_valid)
      else $error("interrupt raised without register delivery");

   // A nonzero player count only travels in a request packet.
   a_info_in_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tx_info != 3'd0) |->
         (rsp_tx_valid && rsp_tx_kind == mlss_pkg::TX_REQUEST))
      else $error("player count sent outside a request packet");

   // The front never pushes into a full queue, so no transaction is lost.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("command queue overflow");

endmodule
